### rtl/core/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and codes shared by the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int CNT_W = 11;
    localparam int IDX_W = 10;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(1024);

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] slot_index;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [ST_W-1:0]  status;
        logic             all_used;
        logic             all_free;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_FIND,
        S_INIT,
        S_DONE
    } t_state;

endpackage

### rtl/core/bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Find-first-free slot allocator over a word-organised free map.
// ----------------------------------------------------------------------------
// One beat at a time. An allocate beat runs through the word pick from the
// non-empty summary with the map read, the find and clear of its first free
// bit, and the report into the result register; release reads the word of its
// index, sets its bit and reports, or reports straight after the range check
// when the index is out of range; init writes one map word per cycle, then
// reports; an unused op code goes straight to the report. The input is ready
// again at the edge that registers the result. The steps are set by the map
// memory's one read port and one write port and by the one leading-one finder,
// which is shared between the word pick and the bit pick. The result register
// lets the next beat be accepted while a result still waits. After reset the
// map reads as all free through per-word valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int MAP_WORDS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bsa_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bsa_pkg::t_out_beat             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [bsa_pkg::CNT_W-1:0]      i_cfg_data
);

    import bsa_pkg::*;

    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WA      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CAP     = MAP_WORDS * WORD_BITS;
    localparam int CAP_W   = $clog2(CAP + 1);
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int WCMP_W  = (WA + 1 > CNT_W - BIT_W + 1) ? WA + 1 : CNT_W - BIT_W + 1;
    localparam int RST_ACT = (CAP < 1024) ? CAP : 1024;

    localparam logic [WORD_BITS-1:0] ONES    = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] MSB_ONE = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic logic [WORD_BITS-1:0] exp_word(input logic [WA-1:0]    w,
                                                      input logic [CNT_W-1:0] act);
        logic [WCMP_W-1:0] wc;
        logic [WCMP_W-1:0] fc;
        logic [BIT_W-1:0]  rem;
        wc  = WCMP_W'(w);
        fc  = WCMP_W'(act >> BIT_W);
        rem = act[BIT_W-1:0];
        if (wc < fc) begin
            return ONES;
        end else if (wc == fc && rem != '0) begin
            return ~(ONES >> rem);
        end
        return '0;
    endfunction

    function automatic logic [BIT_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0]     n;
        logic [WORD_BITS-1:0] t;
        int                   step;
        n = '0;
        t = v;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            step = 1 << k;
            if ((t & ~(ONES >> step)) == '0) begin
                n[k] = 1'b1;
                t    = t << step;
            end
        end
        return n;
    endfunction

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_slot_count;
    logic [CNT_W-1:0]       r_active;
    logic [OP_W-1:0]        r_op;
    logic [IDX_W-1:0]       r_idx;
    logic [WA-1:0]          r_word;
    logic [IDX_W-1:0]       r_granted;
    logic [ST_W-1:0]        r_status;
    logic [MAP_WORDS-1:0]   r_valid;
    logic [MAP_WORDS-1:0]   r_nonempty;
    logic [MAP_WORDS-1:0]   r_fullok;
    logic [WORD_BITS-1:0]   r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0]   r_rd_data;
    logic                   r_rd_valid;
    logic                   r_out_valid;
    t_out_beat              r_out;

    logic                   in_accept;
    logic                   load;
    logic [WORD_BITS-1:0]   rd_word;
    logic [WORD_BITS-1:0]   summary;
    logic [MAP_WORDS-1:0]   used_vec;
    logic [WORD_BITS-1:0]   fin_in;
    logic [BIT_W-1:0]       lz;
    logic                   fz;
    logic                   out_range;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       n_active;
    logic                   flag_used;
    logic                   flag_free;
    logic [WA-1:0]          rd_addr;
    logic                   wr_en;
    logic [WA-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign load      = !r_out_valid || !i_out_stall;
    assign rd_word   = r_rd_valid ? r_rd_data : ONES;
    assign out_range = {1'b0, r_idx} >= r_active;
    assign cfg_ext   = CMP_W'(r_slot_count);
    assign n_active  = (cfg_ext > CMP_W'(CAP)) ? CNT_W'(CAP) : r_slot_count;

    always_comb begin
        logic [WCMP_W-1:0] fc;
        logic [WCMP_W-1:0] wc;
        fc       = WCMP_W'(r_active >> BIT_W);
        summary  = '0;
        used_vec = '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            wc          = WCMP_W'(w);
            used_vec[w] = (wc < fc) || (wc == fc && r_active[BIT_W-1:0] != '0);
            summary[WORD_BITS-1-w] = r_nonempty[w] & used_vec[w];
        end
    end

    assign flag_used = ~|(r_nonempty & used_vec);
    assign flag_free = &(r_fullok | ~used_vec);

    // shared leading-one finder: word pick in S_PICK, bit pick otherwise
    assign fin_in = (r_state == S_PICK) ? summary : rd_word;
    assign lz     = lead_zeros(fin_in);
    assign fz     = (fin_in == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.op)
                        OP_ALLOC, OP_RELEASE: n_state = S_PICK;
                        OP_INIT:              n_state = S_INIT;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_PICK: begin
                if (r_op == OP_ALLOC) begin
                    n_state = fz ? S_DONE : S_FIND;
                end else begin
                    n_state = out_range ? S_DONE : S_FIND;
                end
            end
            S_FIND: n_state = S_DONE;
            S_INIT: begin
                if (r_word == WA'(MAP_WORDS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        rd_addr    = r_word;
        wr_en      = 1'b0;
        wr_addr    = r_word;
        wr_data    = rd_word;
        case (r_state)
            S_PICK: begin
                if (r_op == OP_ALLOC) begin
                    rd_addr = WA'(lz);
                end else begin
                    rd_addr = WA'(r_idx >> BIT_W);
                end
            end
            S_FIND: begin
                wr_en = 1'b1;
                if (r_op == OP_ALLOC) begin
                    wr_data = rd_word & ~(MSB_ONE >> lz);
                end else begin
                    wr_data = rd_word | (MSB_ONE >> r_idx[BIT_W-1:0]);
                end
            end
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = exp_word(r_word, r_active);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_nonempty <= '1;
            r_fullok   <= '1;
        end else if (wr_en) begin
            r_valid[wr_addr]    <= 1'b1;
            r_nonempty[wr_addr] <= |wr_data;
            r_fullok[wr_addr]   <= (wr_data == exp_word(wr_addr, r_active));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= SLOT_COUNT_RST;
            r_active     <= CNT_W'(RST_ACT);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_data;
            end
            if (in_accept && i_in_data.op == OP_INIT) begin
                r_active <= n_active;
            end
            if (r_state == S_DONE && load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= i_in_data.op;
            r_idx     <= i_in_data.slot_index;
            r_word    <= '0;
            r_granted <= '0;
            r_status  <= ST_OK;
        end
        case (r_state)
            S_PICK: begin
                r_word <= rd_addr;
                if (r_op == OP_ALLOC && fz) begin
                    r_status <= ST_NO_FREE;
                end else if (r_op != OP_ALLOC && out_range) begin
                    r_status <= ST_RANGE;
                end
            end
            S_FIND: begin
                if (r_op == OP_ALLOC) begin
                    r_granted <= IDX_W'({r_word, lz});
                end
            end
            S_INIT: begin
                if (r_word != WA'(MAP_WORDS - 1)) begin
                    r_word <= r_word + 1'b1;
                end
            end
            S_DONE: begin
                if (load) begin
                    r_out.granted_index <= r_granted;
                    r_out.status        <= r_status;
                    r_out.all_used      <= flag_used;
                    r_out.all_free      <= flag_free;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_word_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && r_op == OP_ALLOC) |-> !fz)
        else $error("picked word has no free bit");

    a_both_flags_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && load && flag_used && flag_free) |-> (r_active == '0))
        else $error("all_used and all_free together with non-zero count");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted beat not taken up");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside report state");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap slot allocator. A shadow free map
// predicts every result beat, and the checker compares each field. Directed
// beats cover the map after reset, zero, minimum, saturated and partial-word
// slot counts, out-of-range and repeated releases and the unused op code.
// A back-pressure run with one long receiver hold-off and random phases with
// varied counts and op mixes then follow, with random back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import bsa_pkg::*;

    localparam int MAP_WORDS   = 16;
    localparam int CAPACITY    = MAP_WORDS * 64;
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 24;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [63:0] WORD_FREE = {64{1'b1}};

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_beat         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_beat        o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_data  = '0;

    // shadow of the block
    logic [63:0] free_words [MAP_WORDS];
    int          count_reg = 1024;
    int          managed   = 1024;

    t_out_beat   pending_results [$];

    int errors          = 0;
    int beats_sent      = 0;
    int results_seen    = 0;
    int grants          = 0;
    int exhausted       = 0;
    int range_rejects   = 0;
    int inits           = 0;
    int in_stall_cycles = 0;
    int cycles          = 0;
    int hold_left       = 0;
    bit idle_on         = 1'b1;
    bit hold_req        = 1'b0;

    bitmap_slot_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] tail_bits(input int rem);
        return ~((64'd1 << (64 - rem)) - 64'd1);
    endfunction

    function automatic t_out_beat apply_slot_op(input t_in_beat b);
        t_out_beat r;
        int nw;
        int full;
        int rem;
        int lz;
        int idx;
        r = '0;
        idx = int'(b.slot_index);
        case (b.op)
            OP_ALLOC: begin
                nw = (managed + 63) / 64;
                r.status = ST_NO_FREE;
                for (int w = 0; w < nw; w++) begin
                    if (r.status == ST_NO_FREE && free_words[w] != 64'd0) begin
                        lz = 0;
                        while (!free_words[w][63 - lz]) lz++;
                        free_words[w][63 - lz] = 1'b0;
                        r.granted_index = IDX_W'(w * 64 + lz);
                        r.status = ST_OK;
                    end
                end
            end
            OP_RELEASE: begin
                if (idx >= managed) begin
                    r.status = ST_RANGE;
                end else begin
                    free_words[idx / 64][63 - idx % 64] = 1'b1;
                end
            end
            OP_INIT: begin
                managed = (count_reg > CAPACITY) ? CAPACITY : count_reg;
                full = managed / 64;
                rem  = managed % 64;
                for (int w = 0; w < MAP_WORDS; w++) begin
                    free_words[w] = (w < full) ? WORD_FREE : 64'd0;
                end
                if (rem != 0) free_words[full] = tail_bits(rem);
            end
            default: ;
        endcase
        nw   = (managed + 63) / 64;
        full = managed / 64;
        rem  = managed % 64;
        r.all_used = 1'b1;
        for (int w = 0; w < nw; w++) begin
            if (free_words[w] != 64'd0) r.all_used = 1'b0;
        end
        r.all_free = 1'b1;
        for (int w = 0; w < full; w++) begin
            if (free_words[w] != WORD_FREE) r.all_free = 1'b0;
        end
        if (rem != 0 && free_words[full] != tail_bits(rem)) r.all_free = 1'b0;
        return r;
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        t_in_beat  b;
        t_out_beat r;
        b.op = op;
        b.slot_index = idx;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            in_stall_cycles++;
            @(posedge i_clk);
        end
        r = apply_slot_op(b);
        pending_results.push_back(r);
        beats_sent++;
        if (op == OP_INIT) inits++;
        if (op == OP_ALLOC && r.status == ST_OK) grants++;
        if (r.status == ST_NO_FREE) exhausted++;
        if (r.status == ST_RANGE) range_rejects++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // block must be idle before the count register changes
    task automatic write_count(input int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CNT_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_reg = value;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, actual %h", $time, o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.granted_index !== want.granted_index)
                    report_field("granted_index", int'(want.granted_index),
                                 int'(o_out_data.granted_index));
                if (o_out_data.status !== want.status)
                    report_field("status", int'(want.status), int'(o_out_data.status));
                if (o_out_data.all_used !== want.all_used)
                    report_field("all_used", int'(want.all_used), int'(o_out_data.all_used));
                if (o_out_data.all_free !== want.all_free)
                    report_field("all_free", int'(want.all_free), int'(o_out_data.all_free));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic test_reset_map;
        send_beat(OP_ALLOC, '0);
        send_beat(OP_ALLOC, '1);
        send_beat(OP_RELEASE, 10'd1);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_RELEASE, 10'd1023);
        send_beat(OP_UNUSED, 10'd1023);
        send_beat(OP_RELEASE, 10'd0);
    endtask

    task automatic test_count_extremes;
        write_count(0);
        send_beat(OP_INIT, '0);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_RELEASE, 10'd0);
        send_beat(OP_UNUSED, '0);
        write_count(1);
        send_beat(OP_INIT, '1);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_RELEASE, 10'd1);
        send_beat(OP_RELEASE, 10'd0);
        // above capacity, saturates to the full map
        write_count(2047);
        send_beat(OP_INIT, '0);
        send_beat(OP_RELEASE, 10'd1023);
        send_beat(OP_ALLOC, '0);
        write_count(65);
        send_beat(OP_INIT, '0);
        send_beat(OP_RELEASE, 10'd64);
        send_beat(OP_RELEASE, 10'd65);
        write_count(1024);
        send_beat(OP_INIT, '0);
    endtask

    task automatic test_backpressure;
        write_count(96);
        send_beat(OP_INIT, '0);
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(1)) send_beat(OP_ALLOC, IDX_W'($urandom));
            else send_beat(OP_RELEASE, IDX_W'($urandom_range(0, 100)));
        end
        drain();
    endtask

    task automatic test_random_traffic;
        int count;
        int alloc_pct;
        int pick;
        int lim;
        for (int p = 0; p < 13; p++) begin
            case (p)
                0:       count = 1024;
                1:       count = 2047;
                2:       count = 1;
                3:       count = 64;
                default: count = ($urandom_range(99) < 70) ? $urandom_range(1, 160)
                                                           : $urandom_range(0, 2047);
            endcase
            idle_on = (p != 5);
            write_count(count);
            send_beat(OP_INIT, IDX_W'($urandom));
            alloc_pct = $urandom_range(30, 70);
            for (int i = 0; i < 90; i++) begin
                pick = $urandom_range(99);
                lim  = (managed > 0) ? managed - 1 : 0;
                if (pick < alloc_pct) begin
                    send_beat(OP_ALLOC, IDX_W'($urandom));
                end else if (pick < 94) begin
                    if ($urandom_range(99) < 80)
                        send_beat(OP_RELEASE, IDX_W'($urandom_range(0, lim)));
                    else
                        send_beat(OP_RELEASE, IDX_W'($urandom));
                end else if (pick < 97) begin
                    send_beat(OP_INIT, IDX_W'($urandom));
                end else begin
                    send_beat(OP_UNUSED, IDX_W'($urandom));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) free_words[w] = WORD_FREE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_map();
        test_count_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("summary: %0d beats in, %0d results checked; %0d grants, %0d no-free,",
                 beats_sent, results_seen, grants, exhausted);
        $display("summary: %0d rejected releases, %0d inits, counts 0 to 2047, %0d stall cycles",
                 range_rejects, inits, in_stall_cycles);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
